FILE: sv/rc4_pkg.sv
// Shared constants and RAM request types for the RC4 stream cipher block.
// No dependencies; imported by rc4_core and rc4_stream_cipher_top.
`default_nettype none

package rc4_pkg;

    localparam int KEY_DEPTH  = 256;
    localparam int KEY_AW     = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int SBOX_DEPTH = 256;
    localparam int SBOX_AW    = 8;
    localparam int BYTE_W     = 8;
    localparam int KLEN_W     = 9;

    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    typedef struct packed {
        logic                 we;
        logic [SBOX_AW-1:0]   waddr;
        logic [BYTE_W-1:0]    wdata;
        logic [SBOX_AW-1:0]   raddr;
    } sbox_req_t;

    typedef struct packed {
        logic                 we;
        logic [KEY_AW-1:0]    waddr;
        logic [BYTE_W-1:0]    wdata;
        logic [KEY_AW-1:0]    raddr;
    } key_req_t;

endpackage

`default_nettype wire

FILE: sv/rc4_stream_cipher_top.sv
// RC4 stream cipher block, top level: sequencer plus S-box and key-store RAMs.
// Depends on rc4_pkg, rc4_ram and rc4_core.
`default_nettype none

// A key-byte request (func 0) is taken while the block is idle and writes the
// key store. A data-byte request (func 1) holds in_stall high, holding off the
// next request, through PR_RI, PR_J, PR_WI, PR_WJ, PR_RT, PR_OUT and OUT_WAIT;
// the S-box RAM with one read and one write port, behind a single shared 8-bit
// adder, sets these steps. A data byte with first_of_message set first rebuilds
// the S-box: identity fill (INIT), then 256 key-schedule steps of KS_RD, KS_J,
// KS_WN and KS_WJ, all before the byte itself. key_length (cfg_data, reset 16)
// selects how many key bytes repeat; 0 or values above 256 mean 256. Key the
// block and run an opening byte before any other data. The result register
// lets a new request in while a finished byte still waits on out_stall.
module rc4_stream_cipher_top
    import rc4_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              func,
    input  wire logic [7:0]        key_index,
    input  wire logic [7:0]        byte_value,
    input  wire logic              first_of_message,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [7:0]        cipher_byte,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [KLEN_W-1:0] cfg_data
);

    sbox_req_t          sbox_req;
    key_req_t           key_req;
    logic [BYTE_W-1:0]  sbox_rdata;
    logic [BYTE_W-1:0]  key_rdata;

    assign cfg_ready = 1'b1;

    rc4_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .key_index        (key_index),
        .byte_value       (byte_value),
        .first_of_message (first_of_message),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .cipher_byte      (cipher_byte),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .sbox_req         (sbox_req),
        .sbox_rdata       (sbox_rdata),
        .key_req          (key_req),
        .key_rdata        (key_rdata)
    );

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_DEPTH)
    ) u_sbox_ram (
        .clk   (clk),
        .we    (sbox_req.we),
        .waddr (sbox_req.waddr),
        .wdata (sbox_req.wdata),
        .raddr (sbox_req.raddr),
        .rdata (sbox_rdata)
    );

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_req.we),
        .waddr (key_req.waddr),
        .wdata (key_req.wdata),
        .raddr (key_req.raddr),
        .rdata (key_rdata)
    );

endmodule

`default_nettype wire

FILE: sv/rc4_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the S-box and the key store.
`default_nettype none

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/rc4_core.sv
// Sequencer for the RC4 block: key writes, key schedule, PRGA step, output register.
// Depends on rc4_pkg; drives the S-box and key-store RAMs through request structs.
`default_nettype none

module rc4_core
    import rc4_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                func,
    input  wire logic [7:0]          key_index,
    input  wire logic [7:0]          byte_value,
    input  wire logic                first_of_message,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [7:0]          cipher_byte,
    input  wire logic                cfg_valid,
    input  wire logic [KLEN_W-1:0]   cfg_data,
    output sbox_req_t                sbox_req,
    input  wire logic [BYTE_W-1:0]   sbox_rdata,
    output key_req_t                 key_req,
    input  wire logic [BYTE_W-1:0]   key_rdata
);

    typedef enum logic [3:0] {
        IDLE,
        INIT,
        KS_RD,
        KS_J,
        KS_WN,
        KS_WJ,
        PR_RI,
        PR_J,
        PR_WI,
        PR_WJ,
        PR_RT,
        PR_OUT,
        OUT_WAIT
    } state_t;

    state_t              state_reg, state_next;
    logic [SBOX_AW-1:0]  i_reg, i_next;
    logic [SBOX_AW-1:0]  j_reg, j_next;
    logic [SBOX_AW-1:0]  n_reg, n_next;
    logic [KEY_AW-1:0]   k_reg, k_next;
    logic [BYTE_W-1:0]   si_reg, si_next;
    logic [BYTE_W-1:0]   sj_reg, sj_next;
    logic [SBOX_AW-1:0]  t_reg, t_next;
    logic [BYTE_W-1:0]   val_reg, val_next;
    logic [BYTE_W-1:0]   res_reg, res_next;
    logic [BYTE_W-1:0]   cipher_reg, cipher_next;
    logic                out_valid_reg, out_valid_next;
    logic [KLEN_W-1:0]   key_length_reg, key_length_next;

    logic [KLEN_W-1:0]   len_eff;
    logic [KLEN_W-1:0]   k_plus;
    logic                accept;
    logic                n_last;
    logic                load_out;

    // the one shared 8-bit adder
    logic [BYTE_W-1:0]   sum_a, sum_b, sum_c, sum;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != IDLE);
    assign n_last   = (n_reg == SBOX_AW'(SBOX_DEPTH - 1));
    assign load_out = (state_reg == OUT_WAIT) && (!out_valid_reg || !out_stall);
    assign sum      = sum_a + sum_b + sum_c;

    assign len_eff  = (key_length_reg == '0 || key_length_reg > KLEN_W'(KEY_DEPTH))
                      ? KLEN_W'(KEY_DEPTH) : key_length_reg;
    assign k_plus   = KLEN_W'(k_reg) + KLEN_W'(1);

    assign out_valid   = out_valid_reg;
    assign cipher_byte = cipher_reg;

    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        si_next         = si_reg;
        sj_next         = sj_reg;
        t_next          = t_reg;
        val_next        = val_reg;
        res_next        = res_reg;
        cipher_next     = cipher_reg;
        out_valid_next  = out_valid_reg;
        key_length_next = key_length_reg;

        sum_a = '0;
        sum_b = '0;
        sum_c = '0;

        sbox_req.we    = 1'b0;
        sbox_req.waddr = '0;
        sbox_req.wdata = '0;
        sbox_req.raddr = '0;

        key_req.we    = 1'b0;
        key_req.waddr = key_index[KEY_AW-1:0];
        key_req.wdata = byte_value;
        key_req.raddr = k_reg;

        if (cfg_valid)
        begin
            key_length_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_KEY)
                    begin
                        key_req.we = ({1'b0, key_index} < 9'(KEY_DEPTH));
                    end
                    else
                    begin
                        val_next = byte_value;
                        if (first_of_message)
                        begin
                            n_next     = '0;
                            state_next = INIT;
                        end
                        else
                        begin
                            state_next = PR_RI;
                        end
                    end
                end
            end
            INIT:
            begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = n_reg;
                sbox_req.wdata = n_reg;
                n_next         = n_reg + SBOX_AW'(1);
                if (n_last)
                begin
                    j_next     = '0;
                    k_next     = '0;
                    state_next = KS_RD;
                end
            end
            KS_RD:
            begin
                sbox_req.raddr = n_reg;
                state_next     = KS_J;
            end
            KS_J:
            begin
                sum_a          = j_reg;
                sum_b          = sbox_rdata;
                sum_c          = key_rdata;
                si_next        = sbox_rdata;
                j_next         = sum;
                sbox_req.raddr = sum;
                state_next     = KS_WN;
            end
            KS_WN:
            begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = n_reg;
                sbox_req.wdata = sbox_rdata;
                state_next     = KS_WJ;
            end
            KS_WJ:
            begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = j_reg;
                sbox_req.wdata = si_reg;
                n_next         = n_reg + SBOX_AW'(1);
                k_next         = (k_plus >= len_eff) ? '0 : k_plus[KEY_AW-1:0];
                if (n_last)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = PR_RI;
                end
                else
                begin
                    state_next = KS_RD;
                end
            end
            PR_RI:
            begin
                sum_a          = i_reg;
                sum_b          = 8'd1;
                i_next         = sum;
                sbox_req.raddr = sum;
                state_next     = PR_J;
            end
            PR_J:
            begin
                sum_a          = j_reg;
                sum_b          = sbox_rdata;
                si_next        = sbox_rdata;
                j_next         = sum;
                sbox_req.raddr = sum;
                state_next     = PR_WI;
            end
            PR_WI:
            begin
                sj_next        = sbox_rdata;
                sbox_req.we    = 1'b1;
                sbox_req.waddr = i_reg;
                sbox_req.wdata = sbox_rdata;
                state_next     = PR_WJ;
            end
            PR_WJ:
            begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = j_reg;
                sbox_req.wdata = si_reg;
                sum_a          = si_reg;
                sum_b          = sj_reg;
                t_next         = sum;
                state_next     = PR_RT;
            end
            PR_RT:
            begin
                sbox_req.raddr = t_reg;
                state_next     = PR_OUT;
            end
            PR_OUT:
            begin
                res_next   = val_reg ^ sbox_rdata;
                state_next = OUT_WAIT;
            end
            OUT_WAIT:
            begin
                if (load_out)
                begin
                    cipher_next    = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
            si_reg         <= '0;
            sj_reg         <= '0;
            t_reg          <= '0;
            val_reg        <= '0;
            res_reg        <= '0;
            cipher_reg     <= '0;
            out_valid_reg  <= 1'b0;
            key_length_reg <= KLEN_W'(16);
        end
        else
        begin
            state_reg      <= state_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            n_reg          <= n_next;
            k_reg          <= k_next;
            si_reg         <= si_next;
            sj_reg         <= sj_next;
            t_reg          <= t_next;
            val_reg        <= val_next;
            res_reg        <= res_next;
            cipher_reg     <= cipher_next;
            out_valid_reg  <= out_valid_next;
            key_length_reg <= key_length_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/rc4_checker.sv
// Port-level assertions for rc4_stream_cipher_top, attached by bind.
// Depends on the top level's port list only.
`default_nettype none

module rc4_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       func,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] cipher_byte
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cipher_byte))
        else $error("result changed while stalled");

    // key bytes never block the next request
    a_key_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !func |=> !in_stall)
        else $error("stall after key request");

    // a data byte keeps the block busy
    a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func |=> in_stall)
        else $error("no stall after data request");

    // a new result only comes out of a busy cycle
    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while idle");

endmodule

bind rc4_stream_cipher_top rc4_checker u_rc4_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cipher_byte (cipher_byte)
);

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for rc4_stream_cipher_top: key loads, message streams,
// key length sweeps and random stalls, checked against an in-bench RC4 predictor.
// Depends on rc4_pkg and the RTL under sv/.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rc4_pkg::*;

    localparam int KEY_LEN_RESET    = 16;
    localparam int DRAIN_CYCLES     = 20;
    localparam int LONG_HOLD_CYCLES = 3000;
    localparam int PHASE_ITEMS      = 95;
    localparam int MAX_REPORTS      = 50;

    typedef struct packed {
        logic       func;
        logic [7:0] key_index;
        logic [7:0] byte_value;
        logic       first;
    } cipher_req_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              func = FUNC_KEY;
    logic [7:0]        key_index = '0;
    logic [7:0]        byte_value = '0;
    logic              first_of_message = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [7:0]        cipher_byte;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [KLEN_W-1:0] cfg_data = '0;

    // predictor state
    logic [7:0]        sbox_m [SBOX_DEPTH];
    logic [7:0]        key_m [KEY_DEPTH];
    logic [7:0]        idx_i = '0;
    logic [7:0]        idx_j = '0;
    logic [KLEN_W-1:0] key_len_cur = KLEN_W'(KEY_LEN_RESET);

    // request generation state
    bit                key_written [KEY_DEPTH];
    bit                keyed = 1'b0;

    cipher_req_t       pending_bytes [$];
    logic [7:0]        expected_cipher [$];
    cipher_req_t       cur_req;
    int                queued_total = 0;
    int                accepted_total = 0;
    int                error_count = 0;
    bit                idle_on = 1'b1;
    int                send_gap = 0;
    int                recv_gap = 0;
    int                hold_requests = 0;
    int                holds_served = 0;
    int                rx_hold_left = 0;
    bit                offer_free;
    logic [7:0]        want;

    rc4_stream_cipher_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .key_index        (key_index),
        .byte_value       (byte_value),
        .first_of_message (first_of_message),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .cipher_byte      (cipher_byte),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (error_count < MAX_REPORTS)
        begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
        error_count++;
    endtask

    function automatic int unsigned eff_key_len(input logic [KLEN_W-1:0] len);
        return (len == 0 || len > KEY_DEPTH) ? KEY_DEPTH : 32'(len);
    endfunction

    function automatic void swap_sbox(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] tmp;
        tmp       = sbox_m[a];
        sbox_m[a] = sbox_m[b];
        sbox_m[b] = tmp;
    endfunction

    function automatic void predict_cipher(input cipher_req_t r);
        int unsigned len;
        int unsigned k;
        logic [7:0]  j;
        logic [7:0]  i;
        logic [7:0]  t;
        if (r.func == FUNC_KEY)
        begin
            key_m[r.key_index] = r.byte_value;
            return;
        end
        if (r.first)
        begin
            len = eff_key_len(key_len_cur);
            for (int n = 0; n < SBOX_DEPTH; n++)
            begin
                sbox_m[n[7:0]] = n[7:0];
            end
            j = '0;
            k = 0;
            for (int n = 0; n < SBOX_DEPTH; n++)
            begin
                j = j + sbox_m[n[7:0]] + key_m[k[KEY_AW-1:0]];
                swap_sbox(n[7:0], j);
                k++;
                if (k >= len)
                begin
                    k = 0;
                end
            end
            idx_i = '0;
            idx_j = '0;
        end
        i = idx_i + 8'd1;
        j = idx_j + sbox_m[i];
        swap_sbox(i, j);
        t = sbox_m[i] + sbox_m[j];
        idx_i = i;
        idx_j = j;
        expected_cipher.push_back(r.byte_value ^ sbox_m[t]);
    endfunction

    task automatic queue_key(input logic [7:0] idx, input logic [7:0] val, input logic first);
        cipher_req_t r;
        r.func       = FUNC_KEY;
        r.key_index  = idx;
        r.byte_value = val;
        r.first      = first;
        pending_bytes.push_back(r);
        key_written[idx] = 1'b1;
        queued_total++;
    endtask

    task automatic queue_data(input logic [7:0] val, input logic first);
        cipher_req_t r;
        r.func       = FUNC_DATA;
        r.key_index  = 8'($urandom_range(0, 255));
        r.byte_value = val;
        r.first      = first;
        pending_bytes.push_back(r);
        if (first)
        begin
            keyed = 1'b1;
        end
        queued_total++;
    endtask

    // the key schedule must only read key bytes that were loaded
    task automatic fill_missing_keys();
        for (int n = 0; n < eff_key_len(key_len_cur); n++)
        begin
            if (!key_written[n[7:0]])
            begin
                queue_key(n[7:0], 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic queue_traffic(input int n_items);
        int base;
        int choice;
        int msg_len;
        base = queued_total;
        while (queued_total - base < n_items)
        begin
            choice = $urandom_range(0, 9);
            if (choice < 7 || !keyed)
            begin
                fill_missing_keys();
                if ($urandom_range(0, 3) == 0)
                begin
                    queue_key(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                end
                msg_len = $urandom_range(1, 24);
                queue_data(8'($urandom_range(0, 255)), 1'b1);
                for (int n = 1; n < msg_len; n++)
                begin
                    queue_data(8'($urandom_range(0, 255)), 1'b0);
                end
            end
            else if (choice < 9)
            begin
                queue_key(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end
            else
            begin
                queue_data(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    task automatic write_key_length(input logic [KLEN_W-1:0] len);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        key_len_cur = len;
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (accepted_total != queued_total || expected_cipher.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid         <= 1'b0;
            func             <= FUNC_KEY;
            key_index        <= '0;
            byte_value       <= '0;
            first_of_message <= 1'b0;
        end
        else
        begin
            offer_free = !in_valid;
            if (in_valid && !in_stall)
            begin
                predict_cipher(cur_req);
                accepted_total++;
                offer_free = 1'b1;
            end
            if (offer_free)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    cur_req = pending_bytes.pop_front();
                    func             <= cur_req.func;
                    key_index        <= cur_req.key_index;
                    byte_value       <= cur_req.byte_value;
                    first_of_message <= cur_req.first;
                    in_valid         <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0)
                    begin
                        send_gap = $urandom_range(1, 5);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_hold_left <= 0;
            holds_served <= 0;
        end
        else if (holds_served != hold_requests)
        begin
            rx_hold_left <= LONG_HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
        else if (rx_hold_left > 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_cipher.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected cipher_byte %02h", cipher_byte));
                end
                else
                begin
                    want = expected_cipher.pop_front();
                    if (cipher_byte !== want)
                    begin
                        report_mismatch($sformatf("cipher_byte %02h, want %02h",
                                                  cipher_byte, want));
                    end
                end
            end
            if (rx_hold_left > 0)
            begin
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                recv_gap = $urandom_range(0, 4);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int key_lens [10];
        key_lens = '{1, 256, 0, 300, 511, 2, 0, 255, 0, KEY_LEN_RESET};
        key_lens[6] = $urandom_range(3, 254);
        key_lens[8] = $urandom_range(1, 256);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: key extremes, start flag on a key byte, restart mid-stream
        for (int n = 0; n < KEY_LEN_RESET; n++)
        begin
            queue_key(n[7:0],
                      (n == 0) ? 8'h00 : (n == 1) ? 8'hFF : 8'($urandom_range(0, 255)),
                      1'b0);
        end
        queue_key(8'hFF, 8'hAA, 1'b1);
        queue_data(8'h00, 1'b1);
        queue_data(8'hFF, 1'b0);
        queue_data(8'h5A, 1'b0);
        queue_data(8'hFF, 1'b1);
        queue_data(8'h00, 1'b0);
        wait_drained();

        for (int p = 0; p < 10; p++)
        begin
            write_key_length(KLEN_W'(key_lens[p[3:0]]));
            idle_on = (p < 9);
            queue_traffic(PHASE_ITEMS);
            if (p == 1)
            begin
                @(posedge clk);
                hold_requests++;
            end
            wait_drained();
        end

        if (error_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
sv/rc4_pkg.sv
sv/rc4_ram.sv
sv/rc4_core.sv
sv/rc4_stream_cipher_top.sv
sv/rc4_checker.sv
verif/tb_top.sv
